@@ rtl/core/b64d_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// shared types, constants and the character classifier for the base64
// stream decoder
// ----------------------------------------------------------------------------
package b64d_pkg;

   localparam logic [7:0] PAD_CHAR   = 8'h3D;
   localparam logic [7:0] NUL_CHAR   = 8'h00;
   localparam logic [5:0] LOW_NIBBLE = 6'h0F;
   localparam logic [5:0] LOW_PAIR   = 6'h03;

   // result queue geometry
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_OK    = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      CLASS_SYMBOL = 2'd0,
      CLASS_SKIP   = 2'd1,
      CLASS_BAD    = 2'd2
   } char_class_type;

   typedef struct packed {
      char_class_type cls;
      logic [5:0]     value;
   } char_info_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] byte_out;
      logic       last_of_run;
   } result_type;

   // maps a character to its six-bit symbol value, whitespace or bad
   function automatic char_info_type classify(input logic [7:0] c);
      char_info_type info;
      info.cls   = CLASS_BAD;
      info.value = 6'd0;
      priority if (c >= 8'h41 && c <= 8'h5A) begin
         info.cls   = CLASS_SYMBOL;
         info.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         info.cls   = CLASS_SYMBOL;
         info.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         info.cls   = CLASS_SYMBOL;
         info.value = 6'(c - 8'h30 + 8'd52);
      end else if (c == 8'h2B) begin
         info.cls   = CLASS_SYMBOL;
         info.value = 6'd62;
      end else if (c == 8'h2F) begin
         info.cls   = CLASS_SYMBOL;
         info.value = 6'd63;
      end else if (c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h20) begin
         info.cls   = CLASS_SKIP;
      end else begin
         info.cls   = CLASS_BAD;
      end
      return info;
   endfunction

endpackage

@@ rtl/core/base64_stream_decoder_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit
// streaming base64 decoder, standard alphabet, one text character per word
// ----------------------------------------------------------------------------
// Takes one character per cycle on the req channel and decodes it against the
// decoder state at the moment it is accepted; the up to two result words it
// causes (a decoded byte and, on the end-of-text word, a status word) go into
// a four-entry result queue feeding rsp, one word per cycle unless stalled.
// A word is taken every cycle while the queue has room for two results, so a
// plain text stream runs at one character per cycle; only the end-of-text
// word that also completes a byte puts two words into the queue. An accepted
// character's results are written into the registered queue behind any
// words already waiting there. Tab, LF, CR and space are skipped, a pad is
// skipped (a lone pad at group position 1 is an error), NUL stops decoding
// until the end mark, and anything else fails the string. After the status
// word all decoder state is back at reset, ready for the next string; on an
// error status the bytes already sent for the string are void.
// ----------------------------------------------------------------------------
module base64_stream_decoder_unit
   import b64d_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // character words in
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   input  logic       req_end_of_text,
   // result words out
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_byte_out,
   output logic       rsp_last_of_run
);

   // decoder state
   logic [1:0] phase_ff,   phase_in;
   logic [7:0] partial_ff, partial_in;
   logic       pending_ff, pending_in;
   logic       failed_ff,  failed_in;
   logic       stopped_ff, stopped_in;

   // result queue
   result_type             queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;

   logic          req_take;
   logic          rsp_take;
   char_info_type info;
   logic          emit;
   logic [7:0]    emit_byte;
   logic          fail_now;
   result_type    res0;
   result_type    res1;
   logic [1:0]    push_n;

   // hold off new words unless two free slots are left
   assign req_stall = (count_ff > CNT_W'(QUEUE_DEPTH - 2));
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid && !rsp_stall;

   assign info = classify(req_char_in);

   // one character against the current state
   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      pending_in = pending_ff;
      failed_in  = failed_ff;
      stopped_in = stopped_ff;
      emit       = 1'b0;
      emit_byte  = 8'd0;

      if (!failed_ff && !stopped_ff) begin
         pending_in = 1'b0;
         // a pad at position 1 must be followed right away by another pad
         if (pending_ff && req_char_in != PAD_CHAR) begin
            failed_in = 1'b1;
         end else if (req_char_in == NUL_CHAR) begin
            stopped_in = 1'b1;
         end else if (req_char_in == PAD_CHAR) begin
            pending_in = (phase_ff == 2'd1);
         end else if (info.cls == CLASS_BAD) begin
            failed_in = 1'b1;
         end else if (info.cls == CLASS_SYMBOL) begin
            phase_in = phase_ff + 2'd1;
            unique case (phase_ff)
               2'd0: begin
                  partial_in = {info.value, 2'b00};
               end
               2'd1: begin
                  emit       = 1'b1;
                  emit_byte  = partial_ff | {6'd0, info.value[5:4]};
                  partial_in = {4'((info.value & LOW_NIBBLE)), 4'd0};
               end
               2'd2: begin
                  emit       = 1'b1;
                  emit_byte  = partial_ff | {4'd0, info.value[5:2]};
                  partial_in = {2'((info.value & LOW_PAIR)), 6'd0};
               end
               default: begin
                  emit       = 1'b1;
                  emit_byte  = partial_ff | {2'd0, info.value};
                  partial_in = 8'd0;
               end
            endcase
         end
      end

      // end of text: still waiting on the second pad counts as an error
      fail_now = failed_in || pending_in;

      // result words for this character
      res0.kind        = KIND_BYTE;
      res0.byte_out    = emit_byte;
      res0.last_of_run = !req_end_of_text;
      res1.kind        = fail_now ? KIND_ERROR : KIND_OK;
      res1.byte_out    = 8'd0;
      res1.last_of_run = 1'b1;
      push_n           = 2'd0;
      if (emit && req_end_of_text) begin
         push_n = 2'd2;
      end else if (emit) begin
         push_n = 2'd1;
      end else if (req_end_of_text) begin
         push_n = 2'd1;
         res0   = res1;
      end

      // status word sent: back to the reset state
      if (req_end_of_text) begin
         phase_in   = 2'd0;
         partial_in = 8'd0;
         pending_in = 1'b0;
         failed_in  = 1'b0;
         stopped_in = 1'b0;
      end

      if (!req_take) begin
         push_n = 2'd0;
      end

      wr_ptr_in = wr_ptr_ff + PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + PTR_W'(rsp_take);
      count_in  = count_ff + CNT_W'(push_n) - CNT_W'(rsp_take);
   end

   // decoder state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         partial_ff <= 8'd0;
         pending_ff <= 1'b0;
         failed_ff  <= 1'b0;
         stopped_ff <= 1'b0;
         wr_ptr_ff  <= '0;
         rd_ptr_ff  <= '0;
         count_ff   <= '0;
      end else begin
         if (req_take) begin
            phase_ff   <= phase_in;
            partial_ff <= partial_in;
            pending_ff <= pending_in;
            failed_ff  <= failed_in;
            stopped_ff <= stopped_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue payload, no reset needed
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= res0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + PTR_W'(1)] <= res1;
      end
   end

   // head of queue drives the rsp channel
   assign rsp_kind        = queue_ff[rd_ptr_ff].kind;
   assign rsp_byte_out    = queue_ff[rd_ptr_ff].byte_out;
   assign rsp_last_of_run = queue_ff[rd_ptr_ff].last_of_run;

endmodule

@@ rtl/core/b64d_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_checker
// port-level checks for the base64 stream decoder
// ----------------------------------------------------------------------------
module b64d_checker
   import b64d_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_stall,
   input logic       req_end_of_text,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_byte_out,
   input logic       rsp_last_of_run
);

   // no result straight after reset
   a_reset_empty: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result word right after reset");

   // only the three result kinds appear
   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kind == KIND_BYTE || rsp_kind == KIND_OK ||
                     rsp_kind == KIND_ERROR))
      else $error("undefined result kind");

   // status word closes the run and carries no byte
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind != KIND_BYTE) |-> (rsp_last_of_run && rsp_byte_out == 8'd0))
      else $error("malformed status word");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) &&
                                    $stable(rsp_byte_out) && $stable(rsp_last_of_run)))
      else $error("stalled result changed");

   // an accepted end-of-text word always leaves a result behind it
   a_eot_result: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_end_of_text) |=> rsp_valid)
      else $error("no result after end-of-text word");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (.*);

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the base64 stream decoder unit
// ----------------------------------------------------------------------------
// A queue of character words is filled up front: a short directed set for the
// alphabet edges, the pad rule, whitespace, NUL and bytes of 128 and above,
// and then random strings. Most strings are well-formed groups with padding
// and scattered whitespace, some are corrupted and some are pure noise. A
// clocked driver offers the words with random gaps. A clocked monitor stalls
// at random and checks every result word against a decoder model kept here.
// ----------------------------------------------------------------------------
module testbench;
   import b64d_pkg::*;

   localparam int RANDOM_ITEMS = 1500;
   localparam int LONG_HOLD    = 300;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int MAX_REPORTS  = 10;
   localparam int SYM_SKIP     = -1;
   localparam int SYM_BAD      = -2;

   typedef logic [7:0] text_q[$];

   // one character word waiting to be driven
   typedef struct {
      logic [7:0] ch;
      logic       eot;
      int         gap;    // idle cycles before it is offered
      bit         drain;  // hold it back until all results are in
   } char_word_t;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       req_end_of_text = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_byte_out;
   logic       rsp_last_of_run;

   char_word_t char_words[$];
   result_type expected_results[$];

   // decoder model state
   logic [1:0] grp_pos;
   logic [7:0] acc_bits;
   bit         pad_watch;
   bit         str_failed;
   bit         nul_seen;

   // stimulus build state
   bit tx_fast;
   bit drain_next;
   int items_queued;
   int strings_made;

   // driver state
   char_word_t next_word;
   bit         have_next;
   int         gap_left;
   bit         offering;

   // monitor state
   int         stall_left;
   bit         next_stall;
   bit         rx_fast;
   int         words_seen;
   int         mismatches;
   result_type got, want;

   int cycle_count;

   base64_stream_decoder_unit u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_char_in     (req_char_in),
      .req_end_of_text (req_end_of_text),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_byte_out    (rsp_byte_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // six-bit value of an alphabet character, or skip / bad
   function automatic int sym_value(input logic [7:0] c);
      if (c inside {[8'h41:8'h5A]}) return int'(c) - 'h41;
      if (c inside {[8'h61:8'h7A]}) return int'(c) - 'h61 + 26;
      if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30 + 52;
      if (c == 8'h2B) return 62;
      if (c == 8'h2F) return 63;
      if (c inside {8'h09, 8'h0A, 8'h0D, 8'h20}) return SYM_SKIP;
      return SYM_BAD;
   endfunction

   function automatic void clear_decoder();
      grp_pos    = 2'd0;
      acc_bits   = 8'h00;
      pad_watch  = 1'b0;
      str_failed = 1'b0;
      nul_seen   = 1'b0;
   endfunction

   // runs one accepted character through the model, queues its results
   function automatic void decode_char(input logic [7:0] c, input logic eot);
      bit         live;
      bit         emit;
      int         v;
      logic [5:0] sym;
      logic [7:0] dbyte;
      result_type r;
      emit  = 1'b0;
      dbyte = 8'h00;
      live  = !(str_failed || nul_seen);
      // a pad at group position 1 demands a second pad right after it
      if (live && pad_watch) begin
         pad_watch = 1'b0;
         if (c != PAD_CHAR) begin
            str_failed = 1'b1;
            live       = 1'b0;
         end
      end
      if (live) begin
         if (c == NUL_CHAR) begin
            nul_seen = 1'b1;
         end else if (c == PAD_CHAR) begin
            if (grp_pos == 2'd1) pad_watch = 1'b1;
         end else begin
            v = sym_value(c);
            if (v == SYM_BAD) begin
               str_failed = 1'b1;
            end else if (v != SYM_SKIP) begin
               sym = v[5:0];
               case (grp_pos)
                  2'd0: begin
                     acc_bits = {sym, 2'b00};
                  end
                  2'd1: begin
                     dbyte    = acc_bits | {6'b0, sym[5:4]};
                     acc_bits = {sym[3:0], 4'b0};
                     emit     = 1'b1;
                  end
                  2'd2: begin
                     dbyte    = acc_bits | {4'b0, sym[5:2]};
                     acc_bits = {sym[1:0], 6'b0};
                     emit     = 1'b1;
                  end
                  default: begin
                     dbyte    = acc_bits | {2'b0, sym};
                     acc_bits = 8'h00;
                     emit     = 1'b1;
                  end
               endcase
               grp_pos = grp_pos + 2'd1;
            end
         end
      end
      if (emit) begin
         r.kind        = KIND_BYTE;
         r.byte_out    = dbyte;
         r.last_of_run = !eot;
         expected_results.push_back(r);
      end
      if (eot) begin
         if (pad_watch) str_failed = 1'b1;
         r.kind        = str_failed ? KIND_ERROR : KIND_OK;
         r.byte_out    = 8'h00;
         r.last_of_run = 1'b1;
         expected_results.push_back(r);
         clear_decoder();
      end
   endfunction

   function automatic logic [7:0] rand_symbol();
      int i;
      i = $urandom_range(0, 63);
      if (i < 26) return 8'(8'h41 + i);
      if (i < 52) return 8'(8'h61 + i - 26);
      if (i < 62) return 8'(8'h30 + i - 52);
      if (i == 62) return 8'h2B;
      return 8'h2F;
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(0, 3))
         0: return 8'h09;
         1: return 8'h0A;
         2: return 8'h0D;
         default: return 8'h20;
      endcase
   endfunction

   // whole groups, an optional padded tail, whitespace sprinkled in
   function automatic text_q wellformed_text();
      text_q s;
      int    n;
      int    tail;
      int    k;
      s    = {};
      n    = $urandom_range(0, 5) * 4;
      tail = $urandom_range(0, 2);
      if (tail == 1) n += 2;
      if (tail == 2) n += 3;
      for (k = 0; k < n; k++) begin
         if ($urandom_range(0, 7) == 0) s.push_back(rand_space());
         s.push_back(rand_symbol());
      end
      if (tail != 0) s.push_back(PAD_CHAR);
      if (tail == 1) begin
         if ($urandom_range(0, 7) == 0) s.push_back(rand_space());
         s.push_back(PAD_CHAR);
      end
      return s;
   endfunction

   function automatic logic [7:0] noise_char();
      case ($urandom_range(0, 5))
         0: return 8'($urandom_range(0, 255));
         1: return rand_symbol();
         2: return PAD_CHAR;
         3: return rand_space();
         4: return NUL_CHAR;
         default: return 8'($urandom_range(128, 255));
      endcase
   endfunction

   // queue one string, end mark on its last character
   function automatic void push_text(input text_q s);
      char_word_t w;
      int         k;
      for (k = 0; k < s.size(); k++) begin
         w.ch       = s[k];
         w.eot      = (k == s.size() - 1);
         w.gap      = tx_fast ? 0 : $urandom_range(0, 15);
         w.drain    = drain_next;
         drain_next = 1'b0;
         char_words.push_back(w);
         items_queued++;
      end
   endfunction

   // ---------------------------------------------------------------------
   // stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      text_q s;
      int    sel;
      int    k;
      clear_decoder();
      tx_fast      = 1'b0;
      drain_next   = 1'b0;
      items_queued = 0;
      strings_made = 0;

      // directed: a full group ending on a byte, so two results on one word
      push_text('{"T", "W", "F", "u"});
      // pad rule: pad pair after one symbol, pad then symbol, lone pad at
      // the end, pad then NUL
      push_text('{"Q", "=", "="});
      push_text('{"Q", "=", "A"});
      push_text('{"Q", "="});
      push_text('{"Q", "=", NUL_CHAR});
      // whitespace, alphabet ends, NUL then ignored characters
      push_text('{8'h09, 8'h0A, 8'h0D, 8'h20, "/", "+", NUL_CHAR, "z"});
      // bytes of 128 and above, then alphabet edge symbols
      push_text('{8'hFF});
      push_text('{8'h80, "9"});
      push_text('{"A", "Z", "a", "0"});

      // random strings
      while (items_queued < RANDOM_ITEMS) begin
         strings_made++;
         // sender waits for every result now and then
         if (strings_made % 60 == 1) drain_next = 1'b1;
         if (strings_made % 25 == 0) tx_fast = ($urandom_range(0, 2) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            s = wellformed_text();
         end else if (sel < 85) begin
            s = wellformed_text();
            if (s.size() == 0) s.push_back(8'($urandom_range(0, 255)));
            else s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
         end else begin
            s = {};
            for (k = $urandom_range(1, 8); k > 0; k--) s.push_back(noise_char());
         end
         if (s.size() == 0) s.push_back(rand_space());
         push_text(s);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // all words accepted, then all results in, then a short tail
      while (char_words.size() != 0 || have_next || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // driver: offers character words, feeds the model on each accept
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         have_next = 1'b0;
         gap_left  = 0;
      end else begin
         // a word taken at this edge cannot show up on rsp before the next
         if (req_valid && !req_stall) begin
            decode_char(req_char_in, req_end_of_text);
            offering = 1'b0;
         end else begin
            offering = req_valid;
         end
         if (!offering) begin
            if (!have_next && char_words.size() != 0) begin
               next_word = char_words.pop_front();
               have_next = 1'b1;
               gap_left  = next_word.gap;
            end
            if (have_next) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (!next_word.drain || expected_results.size() == 0) begin
                  offering = 1'b1;
                  have_next = 1'b0;
                  req_char_in     <= next_word.ch;
                  req_end_of_text <= next_word.eot;
               end
            end
         end
         req_valid <= offering;
      end
   end

   // ---------------------------------------------------------------------
   // monitor: random stalls, compares each result word in order
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         rx_fast    = 1'b0;
         words_seen = 0;
      end else begin
         next_stall = rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            got.kind        = kind_type'(rsp_kind);
            got.byte_out    = rsp_byte_out;
            got.last_of_run = rsp_last_of_run;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("unexpected result word: kind %0d byte %02h last %0d",
                           got.kind, got.byte_out, got.last_of_run);
            end else begin
               want = expected_results.pop_front();
               if (got.kind !== want.kind || got.byte_out !== want.byte_out ||
                   got.last_of_run !== want.last_of_run) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("mismatch: kind/byte/last expected %0d/%02h/%0d got %0d/%02h/%0d",
                              want.kind, want.byte_out, want.last_of_run,
                              got.kind, got.byte_out, got.last_of_run);
               end
            end
            words_seen++;
            if (words_seen % 150 == 0) rx_fast = ($urandom_range(0, 2) == 0);
            // long hold-off so the result queue fills and req backs up
            if (words_seen == 200 || words_seen == 1000) stall_left = LONG_HOLD;
            else stall_left = rx_fast ? 0 : $urandom_range(0, 15);
            next_stall = (stall_left > 0);
         end else if (stall_left > 0) begin
            stall_left--;
            next_stall = (stall_left > 0);
         end
         rsp_stall <= next_stall;
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

endmodule
